// File: rtl/prpc_pkg.sv
// ----------------------------------------------------------------------------
// prpc_pkg
// Shared widths, register codes and types of the point rotate/project unit.
// ----------------------------------------------------------------------------
package prpc_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_BITS = 14;
  localparam int TRIG_W = 16;
  localparam int FOCAL_W = 8;
  localparam int DIST_W = 17;
  localparam int SCREEN_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int ROT_W = 20;
  localparam int DEN_W = 20;
  localparam int NUM_W = 27;
  localparam int OUT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COS_YAW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_pitch;
    logic signed [TRIG_W-1:0] sin_pitch;
    logic [FOCAL_W-1:0] focal_scale;
    logic [DIST_W-1:0] viewer_distance;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem_col;
    logic [DEN_W-1:0] rem_row;
    logic [NUM_W-1:0] num_col;
    logic [NUM_W-1:0] num_row;
    logic [NUM_W-1:0] quo_col;
    logic [NUM_W-1:0] quo_row;
    logic neg_col;
    logic neg_row;
    logic [DEN_W-1:0] den;
    logic behind;
  } div_t;

endpackage

// File: rtl/point_rotate_project_clip_unit.sv
// ----------------------------------------------------------------------------
// point_rotate_project_clip_unit
// Rotates a Q1.14 point, projects it in perspective and clips it to the screen.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on in_valid/in_ready with coord_x/y/z, one beat per point.
//   Results leave on out_valid/out_ready with screen_col, screen_row,
//   on_screen and behind_viewer, one beat per point, in order.
//   Registers are written on cfg_valid/cfg_ready (always ready) with
//   cfg_index and cfg_data; write them only while no point is in flight.
//   Five stages of rotation and scaling (the input beat loads the first),
//   a chain of 27 divide cells (one quotient bit per cell) and the output
//   register lie between the input beat and the output beat.
//   Throughput is one point per cycle unless in_ready drops; every stage
//   holds its own valid bit, so the chain fills its bubbles while the
//   receiver stalls, and in_ready drops only once every stage is full.
//   Reset clears all valid bits and loads the register defaults
//   (unit trig, focal 25, distance 3.0, screen 80 by 40).
// ----------------------------------------------------------------------------
module point_rotate_project_clip_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] screen_col,
  output logic signed [15:0] screen_row,
  output logic on_screen,
  output logic behind_viewer,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [prpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = prpc_pkg::NUM_W + 2;

  prpc_pkg::cfg_t cfg;
  logic [prpc_pkg::NUM_W:0] cv;
  logic [prpc_pkg::NUM_W:0] cr;
  prpc_pkg::div_t cd [prpc_pkg::NUM_W+1];

  logic fin_ready;
  logic signed [SUM_W-1:0] sc, sr;
  logic signed [prpc_pkg::OUT_W-1:0] col_sat, row_sat;
  logic on_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_yaw <= 16'sd16384;
      cfg.sin_yaw <= '0;
      cfg.cos_pitch <= 16'sd16384;
      cfg.sin_pitch <= '0;
      cfg.focal_scale <= 8'd25;
      cfg.viewer_distance <= 17'd49152;
      cfg.screen_width <= 13'd80;
      cfg.screen_height <= 13'd40;
    end else if (cfg_valid) begin
      case (cfg_index)
        prpc_pkg::REG_COS_YAW: cfg.cos_yaw <= cfg_data[15:0];
        prpc_pkg::REG_SIN_YAW: cfg.sin_yaw <= cfg_data[15:0];
        prpc_pkg::REG_COS_PITCH: cfg.cos_pitch <= cfg_data[15:0];
        prpc_pkg::REG_SIN_PITCH: cfg.sin_pitch <= cfg_data[15:0];
        prpc_pkg::REG_FOCAL: cfg.focal_scale <= cfg_data[7:0];
        prpc_pkg::REG_DIST: cfg.viewer_distance <= cfg_data;
        prpc_pkg::REG_WIDTH: cfg.screen_width <= cfg_data[12:0];
        prpc_pkg::REG_HEIGHT: cfg.screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  prpc_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(cv[0]), .out_ready(cr[0]), .out_data(cd[0])
  );

  for (genvar i = 0; i < prpc_pkg::NUM_W; i++) begin : g_cell
    prpc_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cv[i]), .in_ready(cr[i]), .in_data(cd[i]),
      .out_valid(cv[i+1]), .out_ready(cr[i+1]), .out_data(cd[i+1])
    );
  end

  always_comb begin
    sc = cd[prpc_pkg::NUM_W].neg_col ? -$signed({2'b00, cd[prpc_pkg::NUM_W].quo_col})
                                     : $signed({2'b00, cd[prpc_pkg::NUM_W].quo_col});
    sr = cd[prpc_pkg::NUM_W].neg_row ? -$signed({2'b00, cd[prpc_pkg::NUM_W].quo_row})
                                     : $signed({2'b00, cd[prpc_pkg::NUM_W].quo_row});
    sc = sc + $signed(SUM_W'(cfg.screen_width >> 1));
    sr = sr + $signed(SUM_W'(cfg.screen_height >> 1));
    if (sc > SUM_W'(32767)) col_sat = 16'sh7fff;
    else if (sc < -$signed(SUM_W'(32768))) col_sat = 16'sh8000;
    else col_sat = sc[prpc_pkg::OUT_W-1:0];
    if (sr > SUM_W'(32767)) row_sat = 16'sh7fff;
    else if (sr < -$signed(SUM_W'(32768))) row_sat = 16'sh8000;
    else row_sat = sr[prpc_pkg::OUT_W-1:0];
    on_w = !col_sat[prpc_pkg::OUT_W-1] && !row_sat[prpc_pkg::OUT_W-1]
        && (col_sat[prpc_pkg::OUT_W-2:0] < 15'(cfg.screen_width))
        && (row_sat[prpc_pkg::OUT_W-2:0] < 15'(cfg.screen_height));
  end

  assign fin_ready = !out_valid || out_ready;
  assign cr[prpc_pkg::NUM_W] = fin_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= cv[prpc_pkg::NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && cv[prpc_pkg::NUM_W]) begin
      if (cd[prpc_pkg::NUM_W].behind) begin
        screen_col <= '0;
        screen_row <= '0;
        on_screen <= 1'b0;
        behind_viewer <= 1'b1;
      end else begin
        screen_col <= col_sat;
        screen_row <= row_sat;
        on_screen <= on_w;
        behind_viewer <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/prpc_cell.sv
// ----------------------------------------------------------------------------
// prpc_cell
// One restoring divide step for column and row, with its own pipeline register.
// ----------------------------------------------------------------------------
module prpc_cell (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  prpc_pkg::div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output prpc_pkg::div_t out_data
);

  logic [prpc_pkg::DEN_W:0] trial_col;
  logic [prpc_pkg::DEN_W:0] trial_row;
  logic ge_col;
  logic ge_row;
  prpc_pkg::div_t data_next;

  always_comb begin
    trial_col = {in_data.rem_col, in_data.num_col[prpc_pkg::NUM_W-1]};
    trial_row = {in_data.rem_row, in_data.num_row[prpc_pkg::NUM_W-1]};
    ge_col = trial_col >= {1'b0, in_data.den};
    ge_row = trial_row >= {1'b0, in_data.den};
    data_next = in_data;
    data_next.rem_col = ge_col ? prpc_pkg::DEN_W'(trial_col - {1'b0, in_data.den})
                               : trial_col[prpc_pkg::DEN_W-1:0];
    data_next.rem_row = ge_row ? prpc_pkg::DEN_W'(trial_row - {1'b0, in_data.den})
                               : trial_row[prpc_pkg::DEN_W-1:0];
    data_next.num_col = {in_data.num_col[prpc_pkg::NUM_W-2:0], 1'b0};
    data_next.num_row = {in_data.num_row[prpc_pkg::NUM_W-2:0], 1'b0};
    data_next.quo_col = {in_data.quo_col[prpc_pkg::NUM_W-2:0], ge_col};
    data_next.quo_row = {in_data.quo_row[prpc_pkg::NUM_W-2:0], ge_row};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/prpc_front.sv
// ----------------------------------------------------------------------------
// prpc_front
// Yaw and pitch rotation, depth offset and focal scaling ahead of the divider.
// ----------------------------------------------------------------------------
module prpc_front (
  input  logic clk,
  input  logic rst,
  input  prpc_pkg::cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [prpc_pkg::COORD_W-1:0] coord_x,
  input  logic signed [prpc_pkg::COORD_W-1:0] coord_y,
  input  logic signed [prpc_pkg::COORD_W-1:0] coord_z,
  output logic out_valid,
  input  logic out_ready,
  output prpc_pkg::div_t out_data
);

  localparam int P1_W = 2 * prpc_pkg::COORD_W;
  localparam int P2_W = prpc_pkg::ROT_W + prpc_pkg::TRIG_W;
  localparam int PROD_W = prpc_pkg::ROT_W + prpc_pkg::FOCAL_W + 1;
  localparam logic signed [P2_W:0] HALF = (P2_W+1)'(1) <<< (prpc_pkg::FRAC_BITS - 1);

  logic [3:0] v;
  logic [3:0] adv;

  logic signed [P1_W-1:0] p_xc, p_zs, p_xs, p_zc;
  logic signed [prpc_pkg::COORD_W-1:0] y0;
  logic signed [prpc_pkg::ROT_W-1:0] x1_a, z1, x1_b, x1_c, y2;
  logic signed [prpc_pkg::COORD_W-1:0] y1;
  logic signed [P2_W-1:0] p_yc, p_z1s, p_ys, p_z1c;
  logic signed [prpc_pkg::DEN_W:0] dep;

  logic signed [P2_W:0] s_x1, s_z1, s_y2, s_z2;
  logic signed [prpc_pkg::ROT_W-1:0] z2_w;
  logic signed [PROD_W-1:0] n_col, n_row;
  logic signed [PROD_W-1:0] m_col, m_row;
  logic behind_w;

  assign adv[3] = !out_valid || out_ready;
  assign adv[2] = !v[3] || adv[3];
  assign adv[1] = !v[2] || adv[2];
  assign adv[0] = !v[1] || adv[1];
  assign in_ready = !v[0] || adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v[0] <= in_valid;
      if (adv[0]) v[1] <= v[0];
      if (adv[1]) v[2] <= v[1];
      if (adv[2]) v[3] <= v[2];
      if (adv[3]) out_valid <= v[3];
    end
  end

  always_comb begin
    s_x1 = (P2_W+1)'(p_xc) - (P2_W+1)'(p_zs) + HALF;
    s_z1 = (P2_W+1)'(p_xs) + (P2_W+1)'(p_zc) + HALF;
    s_y2 = (P2_W+1)'(p_yc) - (P2_W+1)'(p_z1s) + HALF;
    s_z2 = (P2_W+1)'(p_ys) + (P2_W+1)'(p_z1c) + HALF;
    z2_w = s_z2[prpc_pkg::FRAC_BITS +: prpc_pkg::ROT_W];
    n_col = PROD_W'(x1_c) * $signed({1'b0, cfg.focal_scale});
    n_row = PROD_W'(y2) * $signed({1'b0, cfg.focal_scale});
    m_col = n_col[PROD_W-1] ? -n_col : n_col;
    m_row = n_row[PROD_W-1] ? -n_row : n_row;
    behind_w = dep[prpc_pkg::DEN_W] || (dep == '0);
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_xc <= coord_x * cfg.cos_yaw;
      p_zs <= coord_z * cfg.sin_yaw;
      p_xs <= coord_x * cfg.sin_yaw;
      p_zc <= coord_z * cfg.cos_yaw;
      y0 <= coord_y;
    end
    if (adv[0] && v[0]) begin
      x1_a <= s_x1[prpc_pkg::FRAC_BITS +: prpc_pkg::ROT_W];
      z1 <= s_z1[prpc_pkg::FRAC_BITS +: prpc_pkg::ROT_W];
      y1 <= y0;
    end
    if (adv[1] && v[1]) begin
      p_yc <= P2_W'(y1) * cfg.cos_pitch;
      p_z1s <= P2_W'(z1) * cfg.sin_pitch;
      p_ys <= P2_W'(y1) * cfg.sin_pitch;
      p_z1c <= P2_W'(z1) * cfg.cos_pitch;
      x1_b <= x1_a;
    end
    if (adv[2] && v[2]) begin
      y2 <= s_y2[prpc_pkg::FRAC_BITS +: prpc_pkg::ROT_W];
      dep <= $signed({z2_w[prpc_pkg::ROT_W-1], z2_w})
           + $signed({{(prpc_pkg::DEN_W + 1 - prpc_pkg::DIST_W){1'b0}},
                      cfg.viewer_distance});
      x1_c <= x1_b;
    end
    if (adv[3] && v[3]) begin
      out_data.rem_col <= '0;
      out_data.rem_row <= '0;
      out_data.quo_col <= '0;
      out_data.quo_row <= '0;
      out_data.num_col <= m_col[prpc_pkg::NUM_W-1:0];
      out_data.num_row <= m_row[prpc_pkg::NUM_W-1:0];
      out_data.neg_col <= n_col[PROD_W-1];
      out_data.neg_row <= n_row[PROD_W-1];
      out_data.behind <= behind_w;
      out_data.den <= behind_w ? prpc_pkg::DEN_W'(1) : dep[prpc_pkg::DEN_W-1:0];
    end
  end

endmodule

// File: rtl/prpc_checker.sv
// ----------------------------------------------------------------------------
// prpc_checker
// Port-level checks of the point rotate/project unit, bound to the top level.
// ----------------------------------------------------------------------------
module prpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] screen_col,
  input logic signed [15:0] screen_row,
  input logic on_screen,
  input logic behind_viewer
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(screen_col) && $stable(screen_row))
    else $error("stalled result beat changed");

  a_behind: assert property (@(posedge clk) disable iff (rst)
    out_valid && behind_viewer |-> !on_screen && screen_col == 16'sd0 && screen_row == 16'sd0)
    else $error("behind viewer result not cleared");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind point_rotate_project_clip_unit prpc_checker u_prpc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .screen_col(screen_col), .screen_row(screen_row),
  .on_screen(on_screen), .behind_viewer(behind_viewer)
);
